// ===== rtl/channel_noise_gain_quantizer_core_macros.svh =====
// assertion macros for the channel noise gain quantizer
// used by the top level; no other dependencies
`ifndef CHANNEL_NOISE_GAIN_QUANTIZER_CORE_MACROS_SVH
`define CHANNEL_NOISE_GAIN_QUANTIZER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CNGQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CNGQ_ASSERT_RAW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CNGQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define CNGQ_ASSERT_RAW(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/cngq_pkg.sv =====
// shared widths and register codes for the channel noise gain quantizer
// no dependencies
`timescale 1ns / 1ps

package cngq_pkg;

    localparam int CH_W      = 6;
    localparam int EST_W     = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = EST_W + FRAC_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int P_W       = QUO_W + 1;
    localparam int SPROD_W   = 32 + CFG_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PCAN_EN  = 2'd0,
        CFG_ALPHA    = 2'd1,
        CFG_STRENGTH = 2'd2,
        CFG_SCALE    = 2'd3
    } t_cfg_idx;

endpackage

// ===== rtl/cngq_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cngq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 40
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cngq_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on cngq_pkg
`timescale 1ns / 1ps

module cngq_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cngq_pkg::QUO_W-1:0] i_dividend,
    input  logic [cngq_pkg::EST_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [cngq_pkg::QUO_W-1:0] o_quotient
);
    import cngq_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0]     r_q;
    logic [EST_W-1:0]     r_rem;
    logic [EST_W-1:0]     r_dvs;
    logic [EST_W:0]       rem_sh;
    logic [EST_W:0]       rem_nx;
    logic                 fits;

    assign rem_sh = {r_rem, r_q[QUO_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[QUO_W-2:0], fits};
            r_rem <= rem_nx[EST_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== rtl/channel_noise_gain_quantizer_core.sv =====
// top level of the channel noise gain quantizer: sequencer, datapath, config
// depends on cngq_pkg, cngq_ram, cngq_div and the assertion macro header
//
//   channel | direction | handshake                 | payload
//   input   | in        | i_in_valid / o_in_stall   | i_channel, i_log_energy
//   output  | out       | o_out_valid / i_out_stall | o_out_channel, o_feature_byte
//   config  | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// one item at a time; a normalized item passes through ram read, estimate update,
// the 40-step divider for energy over noise estimate, multiply, sum, scale and output
// items with pcan off or an out of range channel skip straight to scale and output
// the output register lets the next item be accepted while a result waits
// synchronous active-low reset clears config, seen bits and control; no ram sweep
`timescale 1ns / 1ps
`include "channel_noise_gain_quantizer_core_macros.svh"

module channel_noise_gain_quantizer_core #(
    parameter int NUM_CHANNELS = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [cngq_pkg::CH_W-1:0]      i_channel,
    input  logic [cngq_pkg::EST_W-1:0]     i_log_energy,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cngq_pkg::CH_W-1:0]      o_out_channel,
    output logic [cngq_pkg::BYTE_W-1:0]    o_feature_byte,
    input  logic                           i_cfg_we,
    input  logic [cngq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cngq_pkg::CFG_W-1:0]     i_cfg_data
);
    import cngq_pkg::*;

    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W = EST_W + CFG_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EST, S_DIV, S_MLO, S_MHI, S_SUM, S_SCALE, S_OUT
    } t_state;

    t_state                   r_state;
    logic                     r_pcan;
    logic [CFG_W-1:0]         r_alpha;
    logic [CFG_W-1:0]         r_strength;
    logic [CFG_W-1:0]         r_scale;
    logic [NUM_CHANNELS-1:0]  r_seen;
    logic                     r_ovalid;

    logic [CH_W-1:0]          r_ch;
    logic [EST_W-1:0]         r_e;
    logic [EST_W-1:0]         r_old;
    logic signed [PROD_W-1:0] r_prod;
    logic [EST_W-1:0]         r_t1;
    logic [QUO_W-1:0]         r_lo;
    logic [31:0]              r_hi;
    logic [P_W-1:0]           r_p;
    logic [SPROD_W-1:0]       r_sprod;
    logic                     r_big;
    logic [CH_W-1:0]          r_ochan;
    logic [BYTE_W-1:0]        r_obyte;

    logic                     in_acc;
    logic                     in_active;
    logic [IDX_W-1:0]         ch_idx;
    logic [EST_W-1:0]         ram_rdata;
    logic                     ram_we;
    logic [EST_W-1:0]         old_est;
    logic signed [EST_W:0]    diff;
    logic signed [PROD_W-1:0] prod_c;
    logic [EST_W+1:0]         n_est_sum;
    logic [EST_W-1:0]         n_est;
    logic [EST_W-1:0]         divisor;
    logic [CFG_W:0]           comp_s;
    logic [EST_W+CFG_W:0]     t1_prod;
    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quot;
    logic                     sat;
    logic [BYTE_W-1:0]        byte_c;
    logic                     out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign in_active  = r_pcan && ({1'b0, i_channel} < (CH_W + 1)'(NUM_CHANNELS));
    assign ch_idx     = r_ch[IDX_W-1:0];

    // first item of a channel starts the estimate at its own energy
    assign old_est   = r_seen[ch_idx] ? ram_rdata : r_e;
    assign diff      = signed'({1'b0, r_e}) - signed'({1'b0, old_est});
    assign prod_c    = diff * signed'({1'b0, r_alpha});
    assign n_est_sum = {2'b00, r_old} + r_prod[PROD_W-1:FRAC_W];
    assign n_est     = n_est_sum[EST_W-1:0];
    assign divisor   = (n_est == '0) ? EST_W'(1) : n_est;
    assign comp_s    = {1'b1, CFG_W'(0)} - {1'b0, r_strength};
    assign t1_prod   = r_e * comp_s;

    assign ram_we    = (r_state == S_EST);
    assign div_start = (r_state == S_EST);

    assign sat      = r_big || (|r_sprod[SPROD_W-1:32]);
    assign byte_c   = sat ? '1 : r_sprod[31:32-BYTE_W];
    assign out_free = !r_ovalid || !i_out_stall;

    cngq_ram #(
        .WIDTH (EST_W),
        .DEPTH (NUM_CHANNELS)
    ) u_est_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ch_idx),
        .i_wdata (n_est),
        .i_raddr (i_channel[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    cngq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_e, FRAC_W'(0)}),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pcan     <= 1'b1;
            r_alpha    <= CFG_W'(655);
            r_strength <= CFG_W'(62259);
            r_scale    <= CFG_W'(256);
            r_seen     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PCAN_EN:  r_pcan     <= i_cfg_data[0];
                    CFG_ALPHA:    r_alpha    <= i_cfg_data;
                    CFG_STRENGTH: r_strength <= i_cfg_data;
                    CFG_SCALE:    r_scale    <= i_cfg_data;
                    default:      r_pcan     <= r_pcan;
                endcase
            end
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= in_active ? S_RD : S_SCALE;
                    end
                end
                S_RD:    r_state <= S_EST;
                S_EST: begin
                    r_seen[ch_idx] <= 1'b1;
                    r_state        <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MLO;
                    end
                end
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_SUM;
                S_SUM:   r_state <= S_SCALE;
                S_SCALE: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_ch <= i_channel;
                    r_e  <= i_log_energy;
                    r_p  <= P_W'(i_log_energy);
                end
            end
            S_RD: begin
                r_old  <= old_est;
                r_prod <= prod_c;
            end
            S_EST:   r_t1 <= t1_prod[EST_W+CFG_W-1:CFG_W];
            S_MLO:   r_lo <= div_quot[EST_W-1:0] * r_strength;
            S_MHI:   r_hi <= div_quot[QUO_W-1:EST_W] * r_strength;
            S_SUM: begin
                r_p <= P_W'(r_t1) + {1'b0, r_hi, 8'h00} + P_W'(r_lo[QUO_W-1:FRAC_W]);
            end
            S_SCALE: begin
                r_sprod <= r_p[31:0] * r_scale;
                r_big   <= (|r_p[P_W-1:32]) && (|r_scale);
            end
            S_OUT: begin
                if (out_free) begin
                    r_ochan <= r_ch;
                    r_obyte <= byte_c;
                end
            end
            default: r_ch <= r_ch;
        endcase
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_channel  = r_ochan;
    assign o_feature_byte = r_obyte;

    `CNGQ_ASSERT(a_norm_reads_ram, i_clk, i_rst_n, (in_acc && in_active) |=> (r_state == S_RD), "normalized item did not go to ram read")
    `CNGQ_ASSERT(a_div_start_free, i_clk, i_rst_n, div_start |-> !div_busy, "divider started while busy")
    `CNGQ_ASSERT(a_seen_after_write, i_clk, i_rst_n, ram_we |=> r_seen[ch_idx], "seen bit not set after estimate write")
    `CNGQ_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == S_OUT), "result appeared outside output state")
    `CNGQ_ASSERT_RAW(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !o_out_valid), "reset did not clear sequencer")

endmodule
